[rtl/ibc_pkg.sv]
//------------------------------------------------------------------------------
// ibc_pkg
// Shared types, constants and codes for the interpolated bigram cost block.
//------------------------------------------------------------------------------
package ibc_pkg;

	localparam int unsigned WORDS_DEF   = 65536;
	localparam int unsigned ENTRIES_DEF = 1048576;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIGRAM_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_BIGRAM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_UNIGRAM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE     = 3'd4;

	localparam logic [1:0] REQ_UNIGRAM = 2'd0;
	localparam logic [1:0] REQ_ENTRY   = 2'd1;
	localparam logic [1:0] REQ_HEADER  = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	localparam logic [20:0] LEN_MAX = 21'h1FFFFF;
	localparam logic [16:0] LN2_Q16 = 17'd45426;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [16:0] word_index;
		logic [16:0] prev_word;
		logic [31:0] count;
		logic [19:0] entry_slot;
	} req_t;

	typedef struct packed {
		logic [15:0] cost;
		logic        bigram_hit;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLEAR, ST_WRITE, ST_RD_CUR, ST_WT_CUR, ST_RD_PREV, ST_WT_PREV,
		ST_FLOOR, ST_DIV_FLOOR, ST_UNI, ST_DIV_UNI, ST_PROBE, ST_WT_PROBE, ST_CHECK,
		ST_BIG, ST_DIV_BIG, ST_LOG_NORM, ST_LOG_SQ, ST_LOG_SQ2, ST_LOG_OUT, ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic do_write;
		logic rd_cur;
		logic rd_prev;
		logic cap_cur;
		logic cap_prev;
		logic ld_floor;
		logic ld_uni;
		logic ld_big;
		logic div_step;
		logic add_term;
		logic probe;
		logic check;
		logic log_norm;
		logic log_sq;
		logic log_sq2;
		logic log_out;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic found;
		logic search_end;
		logic log_done;
		logic cur_ok;
		logic prev_ok;
		logic use_big;
		logic uni_ok;
		logic floor_ok;
	} sts_t;

endpackage

[rtl/ibc_if.sv]
//------------------------------------------------------------------------------
// ibc_if
// Valid/ready channel with a generic payload.
//------------------------------------------------------------------------------
interface ibc_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/ibc_ram.sv]
//------------------------------------------------------------------------------
// ibc_ram
// Single port RAM with registered read.
//------------------------------------------------------------------------------
module ibc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[rtl/ibc_ctrl.sv]
//------------------------------------------------------------------------------
// ibc_ctrl
// Sequencer for loads, list clearing, search, division and logarithm.
//------------------------------------------------------------------------------
module ibc_ctrl import ibc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_type,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = (in_type == REQ_QUERY) ? ST_RD_CUR : ST_WRITE;
			end
			ST_WRITE: begin
				cmd.do_write = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RD_CUR: begin
				cmd.rd_cur = 1'b1;
				state_d = ST_WT_CUR;
			end
			ST_WT_CUR: begin
				cmd.cap_cur = 1'b1;
				state_d = ST_RD_PREV;
			end
			ST_RD_PREV: begin
				cmd.rd_prev = 1'b1;
				state_d = ST_WT_PREV;
			end
			ST_WT_PREV: begin
				cmd.cap_prev = 1'b1;
				state_d = ST_FLOOR;
			end
			ST_FLOOR: begin
				cmd.ld_floor = 1'b1;
				state_d = sts.floor_ok ? ST_DIV_FLOOR : ST_UNI;
			end
			ST_DIV_FLOOR: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.add_term = 1'b1;
					state_d = ST_UNI;
				end
			end
			ST_UNI: begin
				cmd.ld_uni = 1'b1;
				if (sts.uni_ok) state_d = ST_DIV_UNI;
				else if (sts.use_big) state_d = ST_PROBE;
				else state_d = ST_LOG_NORM;
			end
			ST_DIV_UNI: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.add_term = 1'b1;
					state_d = sts.use_big ? ST_PROBE : ST_LOG_NORM;
				end
			end
			ST_PROBE: begin
				if (sts.search_end) begin
					state_d = ST_BIG;
				end else begin
					cmd.probe = 1'b1;
					state_d = ST_WT_PROBE;
				end
			end
			ST_WT_PROBE: state_d = ST_CHECK;
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = sts.found ? ST_BIG : ST_PROBE;
			end
			ST_BIG: begin
				cmd.ld_big = 1'b1;
				state_d = sts.prev_ok ? ST_DIV_BIG : ST_LOG_NORM;
			end
			ST_DIV_BIG: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.add_term = 1'b1;
					state_d = ST_LOG_NORM;
				end
			end
			ST_LOG_NORM: begin
				cmd.log_norm = 1'b1;
				state_d = sts.log_done ? ST_LOG_OUT : ST_LOG_SQ;
			end
			ST_LOG_SQ: begin
				cmd.log_sq = 1'b1;
				state_d = ST_LOG_SQ2;
			end
			ST_LOG_SQ2: begin
				cmd.log_sq2 = 1'b1;
				state_d = sts.log_done ? ST_LOG_OUT : ST_LOG_SQ;
			end
			ST_LOG_OUT: begin
				cmd.log_out = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/ibc_dp.sv]
//------------------------------------------------------------------------------
// ibc_dp
// Datapath: count stores, entry store, search registers, restoring divider,
// squaring logarithm and cost scaling.
//------------------------------------------------------------------------------
module ibc_dp import ibc_pkg::*; #(
	parameter int WORDS   = WORDS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  req_t  req,
	input  logic  cfg_fire,
	input  cfg_t  cfg,
	input  cmd_t  cmd,
	output sts_t  sts,
	output rsp_t  rsp
);
	localparam int WA = $clog2(WORDS);
	localparam int EA = $clog2(ENTRIES);

	// configuration
	logic        bigram_enable_q;
	logic [15:0] lambda_bigram_q, lambda_unigram_q;
	logic [31:0] total_count_q, vocab_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bigram_enable_q  <= 1'b1;
			lambda_bigram_q  <= 16'd52429;
			lambda_unigram_q <= 16'd6554;
			total_count_q    <= 32'd1;
			vocab_size_q     <= 32'd65536;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				CFG_BIGRAM_ENABLE:  bigram_enable_q  <= cfg.data[0];
				CFG_LAMBDA_BIGRAM:  lambda_bigram_q  <= cfg.data[15:0];
				CFG_LAMBDA_UNIGRAM: lambda_unigram_q <= cfg.data[15:0];
				CFG_TOTAL_COUNT:    total_count_q    <= cfg.data;
				CFG_VOCAB_SIZE:     vocab_size_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	req_t req_q;
	always_ff @(posedge clk) begin
		if (in_fire) req_q <= req;
	end

	logic cur_ok, prev_ok, slot_ok;
	assign cur_ok  = !req_q.word_index[16] && ({15'd0, req_q.word_index[15:0]} < 31'(WORDS));
	assign prev_ok = !req_q.prev_word[16] && ({15'd0, req_q.prev_word[15:0]} < 31'(WORDS));
	assign slot_ok = {12'd0, req_q.entry_slot} < 32'(ENTRIES);

	// clearing pass over list lengths
	logic [WA:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
	end

	// word-indexed memories
	logic [WA-1:0] waddr;
	logic          uni_we, hdr_we, len_we;
	logic [31:0]   uni_rd;
	logic [19:0]   start_rd;
	logic [20:0]   len_rd, len_wd;

	always_comb begin
		waddr = WA'(req_q.word_index[15:0]);
		if (cmd.clr_step) waddr = clr_q[WA-1:0];
		else if (cmd.rd_prev) waddr = WA'(req_q.prev_word[15:0]);
	end
	assign uni_we = cmd.do_write && req_q.req_type == REQ_UNIGRAM && cur_ok;
	assign hdr_we = cmd.do_write && req_q.req_type == REQ_HEADER && cur_ok;
	assign len_we = hdr_we || cmd.clr_step;
	assign len_wd = cmd.clr_step ? '0 :
		(req_q.count > {11'd0, LEN_MAX}) ? LEN_MAX : req_q.count[20:0];

	ibc_ram #(.WIDTH(32), .DEPTH(WORDS)) u_uni (
		.clk(clk), .we(uni_we), .addr(waddr), .wdata(req_q.count), .rdata(uni_rd));
	ibc_ram #(.WIDTH(20), .DEPTH(WORDS)) u_start (
		.clk(clk), .we(hdr_we), .addr(waddr), .wdata(req_q.entry_slot), .rdata(start_rd));
	ibc_ram #(.WIDTH(21), .DEPTH(WORDS)) u_len (
		.clk(clk), .we(len_we), .addr(waddr), .wdata(len_wd), .rdata(len_rd));

	logic [31:0] cnt_cur_q, cnt_prev_q;
	logic [19:0] start_q;
	always_ff @(posedge clk) begin
		if (cmd.cap_cur) begin
			cnt_cur_q <= uni_rd;
			start_q   <= start_rd;
		end
		if (cmd.cap_prev) cnt_prev_q <= uni_rd;
	end

	// search bounds, signed to allow up = -1
	logic signed [22:0] low_q, up_q;
	logic signed [22:0] mid;
	logic [EA-1:0]      eaddr;
	logic [15:0]        eprev_rd;
	logic [31:0]        ecount_rd;
	logic               ent_we;
	logic               hit_q;
	logic [31:0]        bc_q;
	logic [EA:0]        sum_addr;

	assign mid = (low_q + up_q) >>> 1;
	assign sum_addr = (EA+1)'({3'd0, start_q}) + (EA+1)'(mid[21:0]);
	assign ent_we = cmd.do_write && req_q.req_type == REQ_ENTRY && slot_ok;
	assign eaddr = ent_we ? EA'(req_q.entry_slot) : sum_addr[EA-1:0];

	ibc_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_eprev (
		.clk(clk), .we(ent_we), .addr(eaddr), .wdata(req_q.prev_word[15:0]), .rdata(eprev_rd));
	ibc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ecnt (
		.clk(clk), .we(ent_we), .addr(eaddr), .wdata(req_q.count), .rdata(ecount_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			low_q <= '0;
			up_q  <= '0;
		end else if (cmd.cap_cur) begin
			hit_q <= 1'b0;
			low_q <= '0;
			up_q  <= $signed({2'b00, len_rd}) - 23'sd1;
		end else if (cmd.check) begin
			if (eprev_rd == req_q.prev_word[15:0]) hit_q <= 1'b1;
			else if (eprev_rd > req_q.prev_word[15:0]) up_q <= mid - 23'sd1;
			else low_q <= mid + 23'sd1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.cap_cur) bc_q <= '0;
		else if (cmd.check && eprev_rd == req_q.prev_word[15:0]) bc_q <= ecount_rd;
	end

	// restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle
	logic [31:0] dvs_q;
	logic [32:0] rem_q;
	logic [16:0] left;
	logic [16:0] lsum;

	assign lsum = {1'b0, lambda_bigram_q} + {1'b0, lambda_unigram_q};
	assign left = lsum[16] ? 17'd0 : 17'h10000 - lsum;

	// numerators are built a product at a time: l*c is 48 bits, shifted 16
	logic [47:0] num;
	always_comb begin
		num = '0;
		if (cmd.ld_floor) num = {31'd0, left};
		else if (cmd.ld_uni) num = 48'(lambda_unigram_q) * 48'(cnt_cur_q);
		else if (cmd.ld_big) num = 48'(lambda_bigram_q) * 48'(bc_q);
	end

	// quotient capped at 2^32, so track overflow
	logic [63:0] dvd64_q;
	logic [63:0] quo_q;
	logic [33:0] r_sh, r_sub;
	assign r_sh  = {rem_q, dvd64_q[63]};
	assign r_sub = r_sh - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.ld_floor || cmd.ld_uni || cmd.ld_big) begin
			dvd64_q <= {num, 16'd0};
			rem_q   <= '0;
			quo_q   <= '0;
			dvs_q   <= cmd.ld_floor ? vocab_size_q : cmd.ld_uni ? total_count_q : cnt_prev_q;
		end else if (cmd.div_step && !sts.div_done) begin
			dvd64_q <= {dvd64_q[62:0], 1'b0};
			if (!r_sub[33]) begin
				rem_q <= r_sub[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= r_sh[32:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
	// one step per dividend bit; leading zeros of the 64-bit dividend still cost cycles
	logic [6:0] dstep_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dstep_q <= '0;
		else if (cmd.ld_floor || cmd.ld_uni || cmd.ld_big) dstep_q <= '0;
		else if (cmd.div_step && !sts.div_done) dstep_q <= dstep_q + 1'b1;
	end

	// running sum, Q1.32 capped at 2^32
	logic [32:0] sum_q, term, sum_add;
	logic [33:0] sum_raw;
	assign term = (quo_q[63:32] != 0 && !(quo_q[63:33] == 0 && quo_q[31:0] == 0 && quo_q[32]))
		? 33'h100000000 : quo_q[32:0];
	assign sum_raw = {1'b0, sum_q} + {1'b0, term};
	assign sum_add = (sum_raw > 34'h100000000) ? 33'h100000000 : sum_raw[32:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_cur) sum_q <= '0;
		else if (cmd.add_term) sum_q <= sum_add;
	end

	// logarithm by repeated squaring
	logic [32:0] m_q;
	logic [4:0]  e_q;
	logic [15:0] f_q;
	logic [4:0]  it_q;
	logic        zero_q, sat_q;
	logic [65:0] sq_q;
	logic [4:0]  e_n;
	logic [15:0] cost_q;

	always_comb begin
		e_n = '0;
		for (int i = 0; i < 32; i++) begin
			if (sum_q[i]) e_n = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log_norm) begin
			e_q    <= e_n;
			m_q    <= {1'b0, sum_q[31:0] << (5'd31 - e_n)};
			f_q    <= '0;
			it_q   <= '0;
			zero_q <= sum_q == 0;
			sat_q  <= sum_q[32];
		end else if (cmd.log_sq) begin
			sq_q <= m_q * m_q;
		end else if (cmd.log_sq2) begin
			it_q <= it_q + 1'b1;
			if (sq_q[63]) begin
				f_q <= {f_q[14:0], 1'b1};
				m_q <= {1'b0, sq_q[63:32]};
			end else begin
				f_q <= {f_q[14:0], 1'b0};
				m_q <= {1'b0, sq_q[62:31]};
			end
		end
	end

	logic [21:0] dlog;
	logic [38:0] prod;
	logic [38:0] c_full;
	assign dlog   = 22'h200000 - {1'b0, e_q, f_q};
	assign prod   = dlog * LN2_Q16;
	assign c_full = (prod + 39'h800000) >> 24;

	always_ff @(posedge clk) begin
		if (cmd.log_out) begin
			if (zero_q) cost_q <= 16'hFFFF;
			else if (sat_q) cost_q <= '0;
			else cost_q <= (c_full > 39'd65535) ? 16'hFFFF : c_full[15:0];
		end
	end

	assign rsp.cost       = cost_q;
	assign rsp.bigram_hit = hit_q;

	assign sts.clr_done   = clr_q[WA-1:0] == WA'(WORDS - 1);
	assign sts.div_done   = dstep_q == 7'd64;
	assign sts.found      = eprev_rd == req_q.prev_word[15:0];
	assign sts.search_end = low_q > up_q;
	// sixteenth squaring step ends the loop
	assign sts.log_done   = cmd.log_norm ? (sum_q == 0 || sum_q[32]) : (it_q == 5'd15);
	assign sts.cur_ok     = cur_ok;
	assign sts.prev_ok    = cnt_prev_q != 0;
	assign sts.use_big    = cur_ok && prev_ok && bigram_enable_q;
	assign sts.uni_ok     = cur_ok && total_count_q != 0;
	assign sts.floor_ok   = vocab_size_q != 0;
endmodule

[rtl/interpolated_bigram_cost.sv]
//------------------------------------------------------------------------------
// interpolated_bigram_cost
// Interpolated bigram language model cost unit.
//------------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready). Count, entry and header writes
// give no result. A query gives one transaction on rsp carrying the Q8.8
// cost and the bigram hit flag. It runs the lookups, up to three restoring
// divisions, a binary search of up to 21 probes and repeated squaring for
// the logarithm.
// Configuration writes arrive on cfg (index, data) and are taken at any time;
// write them only while no query is in flight.
// After reset the block clears the list lengths of all WORDS words, one word
// a cycle, with req not ready. Registers take their default values.
// If rsp is stalled the result holds and req stays not ready until taken.
//------------------------------------------------------------------------------
module interpolated_bigram_cost import ibc_pkg::*; #(
	parameter int WORDS   = WORDS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	ibc_if.sink   req,
	ibc_if.sink   cfg,
	ibc_if.source rsp
);
	cmd_t cmd;
	sts_t sts;
	rsp_t rsp_d;

	assign cfg.ready = 1'b1;

	ibc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_type(req.data.req_type), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd));

	ibc_dp #(.WORDS(WORDS), .ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_fire(req.valid && req.ready), .req(req.data),
		.cfg_fire(cfg.valid), .cfg(cfg.data),
		.cmd(cmd), .sts(sts), .rsp(rsp_d));

	assign rsp.data = rsp_d;
endmodule
